### rtl/rv64_pkg.sv
// shared types, opcodes and helpers for the rv64im alu
package rv64_pkg;

  localparam int DataWidth = 64;
  localparam int LatWidth = 6;

  typedef enum logic [4:0] {
    OP_NOP = 5'd0, OP_ADD = 5'd1, OP_MUL = 5'd2, OP_SUB = 5'd3, OP_SLL = 5'd4,
    OP_MULH = 5'd5, OP_MULHSU = 5'd6, OP_MULHU = 5'd7, OP_SLT = 5'd8, OP_SLTU = 5'd9,
    OP_XOR = 5'd10, OP_DIV = 5'd11, OP_DIVU = 5'd12, OP_SRL = 5'd13, OP_SRA = 5'd14,
    OP_OR = 5'd15, OP_REM = 5'd16, OP_REMU = 5'd17, OP_AND = 5'd18, OP_ADDW = 5'd19,
    OP_SUBW = 5'd20, OP_SLLW = 5'd21, OP_SRLW = 5'd22, OP_SRAW = 5'd23, OP_MULW = 5'd24,
    OP_DIVW = 5'd25, OP_REMW = 5'd26, OP_REMUW = 5'd27
  } op_t;

  localparam logic [1:0] RegMulLat = 2'd0;
  localparam logic [1:0] RegDivLat = 2'd1;
  localparam logic [1:0] RegRemLat = 2'd2;

  localparam logic [LatWidth-1:0] MulLatReset = 6'd2;
  localparam logic [LatWidth-1:0] DivLatReset = 6'd40;
  localparam logic [LatWidth-1:0] RemLatReset = 6'd40;

  typedef struct packed {
    logic [4:0]          cmd;
    logic [63:0]         operand_a;
    logic [63:0]         operand_b;
    logic [63:0]         passthrough_value;
    logic [LatWidth-1:0] latency_in;
  } in_item_t;

  typedef struct packed {
    logic [63:0]         result;
    logic [LatWidth-1:0] latency_out;
  } out_item_t;

  // unit classes
  typedef enum logic [1:0] {
    CLS_SIMPLE = 2'd0, CLS_MUL = 2'd1, CLS_DIV = 2'd2
  } cls_t;

  // classified item between front and back
  typedef struct packed {
    logic [4:0]          cmd;
    cls_t                cls;
    logic [63:0]         operand_a;
    logic [63:0]         operand_b;
    logic [63:0]         passthrough_value;
    logic [LatWidth-1:0] latency;
  } work_t;

  function automatic logic [63:0] sext32(input logic [31:0] x);
    sext32 = {{32{x[31]}}, x};
  endfunction

endpackage

### rtl/rv64_front.sv
// front: classifies items and resolves the modelled latency
module rv64_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  rv64_pkg::in_item_t item,
  input  logic [5:0]         mul_latency,
  input  logic [5:0]         div_latency,
  input  logic [5:0]         rem_latency,
  output rv64_pkg::work_t    work
);
  import rv64_pkg::*;

  logic        prev_was_mul, prev_was_div, prev_div_unsigned;
  logic [63:0] prev_operand_a, prev_operand_b;
  logic        is_mul, is_div, is_rem, rem_u, known, is_divu_next;
  logic        same, fused;
  cls_t        cls;

  always_comb begin
    is_mul = 1'b0;
    is_div = 1'b0;
    is_rem = 1'b0;
    rem_u = 1'b0;
    known = 1'b1;
    is_divu_next = prev_div_unsigned;
    cls = CLS_SIMPLE;
    case (item.cmd)
      OP_MUL, OP_MULH, OP_MULHSU, OP_MULHU: begin
        is_mul = 1'b1;
        cls = CLS_MUL;
      end
      OP_MULW: cls = CLS_MUL;
      OP_DIV, OP_DIVW: begin
        is_div = 1'b1;
        is_divu_next = 1'b0;
        cls = CLS_DIV;
      end
      OP_DIVU: begin
        is_div = 1'b1;
        is_divu_next = 1'b1;
        cls = CLS_DIV;
      end
      OP_REM, OP_REMW: begin
        is_rem = 1'b1;
        cls = CLS_DIV;
      end
      OP_REMU, OP_REMUW: begin
        is_rem = 1'b1;
        rem_u = 1'b1;
        cls = CLS_DIV;
      end
      default: known = (item.cmd <= 5'(OP_REMUW));
    endcase
  end

  assign same = (item.operand_a == prev_operand_a) && (item.operand_b == prev_operand_b);
  assign fused = prev_was_div && same && (prev_div_unsigned == rem_u);

  always_comb begin
    work.cmd = item.cmd;
    work.cls = cls;
    work.operand_a = item.operand_a;
    work.operand_b = item.operand_b;
    work.passthrough_value = item.passthrough_value;
    if (is_mul) begin
      if (prev_was_mul) work.latency = (mul_latency == '0) ? '0 : mul_latency - 6'd1;
      else work.latency = mul_latency;
    end else if (is_div) begin
      work.latency = div_latency;
    end else if (is_rem) begin
      work.latency = fused ? '0 : rem_latency;
    end else begin
      work.latency = item.latency_in;
    end
  end

  // history advances when the item is accepted
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_was_mul <= 1'b0;
      prev_was_div <= 1'b0;
      prev_div_unsigned <= 1'b0;
      prev_operand_a <= '0;
      prev_operand_b <= '0;
    end else if (take) begin
      if (known) begin
        prev_was_mul <= is_mul;
        prev_was_div <= is_div;
      end
      prev_div_unsigned <= is_divu_next;
      prev_operand_a <= item.operand_a;
      prev_operand_b <= item.operand_b;
    end
  end
endmodule

### rtl/rv64_fifo.sv
// two-entry queue between front and back
module rv64_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rv64_pkg::work_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output rv64_pkg::work_t pop_data
);
  import rv64_pkg::*;

  work_t      mem [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign pop_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

### rtl/rv64_back.sv
// back: simple ops computed directly from the item, multiplier in four partial products, radix-2 divider
module rv64_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  rv64_pkg::work_t   work,
  output logic              busy,
  output logic              done,
  output rv64_pkg::out_item_t res
);
  import rv64_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001, ST_MUL = 4'b0010, ST_DIV = 4'b0100, ST_FIX = 4'b1000
  } state_t;

  state_t       state;
  work_t        w;
  logic [63:0]  simple_res;
  logic [5:0]   sh6;
  logic [4:0]   sh5;
  // multiplier
  logic [1:0]   mstep;
  logic [127:0] macc;
  logic [31:0]  ma, mb;
  logic [63:0]  mprod;
  logic [63:0]  mua, mub;
  // divider
  logic [6:0]   dcnt;
  logic [63:0]  dq, dr, dd;
  logic         dneg_q, dneg_r, dzero, dovf, dword, drem;
  logic         drem_r, dword_r;
  logic [64:0]  dtrial;
  logic [63:0]  da, db, qv, rv, dv;

  assign sh6 = work.operand_b[5:0];
  assign sh5 = work.operand_b[4:0];
  assign busy = (state != ST_IDLE);

  always_comb begin
    case (work.cmd)
      OP_ADD:  simple_res = work.operand_a + work.operand_b;
      OP_SUB:  simple_res = work.operand_a - work.operand_b;
      OP_SLL:  simple_res = work.operand_a << sh6;
      OP_SLT:  simple_res = {63'd0, $signed(work.operand_a) < $signed(work.operand_b)};
      OP_SLTU: simple_res = {63'd0, work.operand_a < work.operand_b};
      OP_XOR:  simple_res = work.operand_a ^ work.operand_b;
      OP_SRL:  simple_res = work.operand_a >> sh6;
      OP_SRA:  simple_res = 64'($signed(work.operand_a) >>> sh6);
      OP_OR:   simple_res = work.operand_a | work.operand_b;
      OP_AND:  simple_res = work.operand_a & work.operand_b;
      OP_ADDW: simple_res = sext32(work.operand_a[31:0] + work.operand_b[31:0]);
      OP_SUBW: simple_res = sext32(work.operand_a[31:0] - work.operand_b[31:0]);
      OP_SLLW: simple_res = sext32(work.operand_a[31:0] << sh5);
      OP_SRLW: simple_res = sext32(work.operand_a[31:0] >> sh5);
      OP_SRAW: simple_res = sext32(32'($signed(work.operand_a[31:0]) >>> sh5));
      default: simple_res = work.passthrough_value;
    endcase
  end

  // unsigned product, then signed corrections on the high half
  assign mua = w.operand_a;
  assign mub = w.operand_b;
  always_comb begin
    case (mstep)
      2'd0: begin ma = mua[31:0];  mb = mub[31:0];  end
      2'd1: begin ma = mua[31:0];  mb = mub[63:32]; end
      2'd2: begin ma = mua[63:32]; mb = mub[31:0];  end
      default: begin ma = mua[63:32]; mb = mub[63:32]; end
    endcase
  end
  assign mprod = ma * mb;

  // signed magnitude setup for the divider
  always_comb begin
    dword = (work.cmd == OP_DIVW) || (work.cmd == OP_REMW) || (work.cmd == OP_REMUW);
    drem = (work.cmd == OP_REM) || (work.cmd == OP_REMU) || (work.cmd == OP_REMW)
        || (work.cmd == OP_REMUW);
    if (work.cmd == OP_REMUW) begin
      da = {32'd0, work.operand_a[31:0]};
      db = {32'd0, work.operand_b[31:0]};
    end else if (dword) begin
      da = sext32(work.operand_a[31:0]);
      db = sext32(work.operand_b[31:0]);
    end else begin
      da = work.operand_a;
      db = work.operand_b;
    end
  end

  logic dsigned;
  assign dsigned = (work.cmd == OP_DIV) || (work.cmd == OP_REM) || (work.cmd == OP_DIVW)
      || (work.cmd == OP_REMW);

  assign dtrial = {dr, dq[63]} - {1'b0, dd};

  logic [63:0] rq, rr;
  assign rq = dneg_q ? 64'd0 - dq : dq;
  assign rr = dneg_r ? 64'd0 - dr : dr;

  // zero divisor and overflow override the magnitude result
  always_comb begin
    if (dzero) begin
      qv = '1;
      rv = dv;
    end else if (dovf) begin
      qv = dv;
      rv = '0;
    end else begin
      qv = rq;
      rv = rr;
    end
  end

  logic [63:0] mhi, mfinal;
  always_comb begin
    mhi = macc[127:64];
    case (w.cmd)
      OP_MULH:   mhi = macc[127:64] - (w.operand_a[63] ? w.operand_b : 64'd0)
          - (w.operand_b[63] ? w.operand_a : 64'd0);
      OP_MULHSU: mhi = macc[127:64] - (w.operand_a[63] ? w.operand_b : 64'd0);
      default:   mhi = macc[127:64];
    endcase
    case (w.cmd)
      OP_MUL:  mfinal = macc[63:0];
      OP_MULW: mfinal = sext32(macc[31:0]);
      default: mfinal = mhi;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: if (start) begin
          w <= work;
          res.latency_out <= work.latency;
          case (work.cls)
            CLS_MUL: begin
              mstep <= 2'd0;
              macc <= '0;
              state <= ST_MUL;
            end
            CLS_DIV: begin
              dzero <= (db == 64'd0);
              dovf <= dsigned && (da == {1'b1, 63'd0}) && (db == '1);
              if (dsigned) begin
                dq <= da[63] ? 64'd0 - da : da;
                dd <= db[63] ? 64'd0 - db : db;
                dneg_q <= da[63] ^ db[63];
                dneg_r <= da[63];
              end else begin
                dq <= da;
                dd <= db;
                dneg_q <= 1'b0;
                dneg_r <= 1'b0;
              end
              dv <= da;
              dr <= '0;
              dcnt <= 7'd0;
              state <= ST_DIV;
            end
            default: begin
              res.result <= simple_res;
              done <= 1'b1;
            end
          endcase
        end
        ST_MUL: begin
          case (mstep)
            2'd0: macc <= macc + {64'd0, mprod};
            2'd1: macc <= macc + {32'd0, mprod, 32'd0};
            2'd2: macc <= macc + {32'd0, mprod, 32'd0};
            default: macc <= macc + {mprod, 64'd0};
          endcase
          mstep <= mstep + 2'd1;
          if (mstep == 2'd3) state <= ST_FIX;
        end
        ST_DIV: begin
          if (!dtrial[64]) begin
            dr <= dtrial[63:0];
            dq <= {dq[62:0], 1'b1};
          end else begin
            dr <= {dr[62:0], dq[63]};
            dq <= {dq[62:0], 1'b0};
          end
          dcnt <= dcnt + 7'd1;
          if (dcnt == 7'd63) state <= ST_FIX;
        end
        ST_FIX: begin
          if (w.cls == CLS_MUL) begin
            res.result <= mfinal;
          end else begin
            if (drem_r) res.result <= dword_r ? sext32(rv[31:0]) : rv;
            else res.result <= dword_r ? sext32(qv[31:0]) : qv;
          end
          done <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      drem_r <= drem;
      dword_r <= dword;
    end
  end
endmodule

### rtl/rv64im_alu_with_latency_model_core.sv
// top level: rv64im alu with modelled latency
// the back end takes one item at a time from the queue, when idle and the output register
// is free; simple ops finish directly, multiplies and divisions step through their unit
// and a fix-up state, and each result beat waits in the output register until taken
// a two-entry queue lets the front keep accepting while the back works
// reset (rst, synchronous): queue empty, history and latency registers to defaults
module rv64im_alu_with_latency_model_core #(
  parameter int DATA_WIDTH = rv64_pkg::DataWidth
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rv64_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rv64_pkg::out_item_t  out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import rv64_pkg::*;

  logic [5:0] mul_latency, div_latency, rem_latency;
  logic       cfg_we;
  logic [1:0] cfg_idx;
  work_t      fwork, qwork;
  logic       qfull, qempty, qpop, take;
  logic       bbusy, bdone;
  out_item_t  bres;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  // config registers, reset to the modelled defaults
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_latency <= MulLatReset;
      div_latency <= DivLatReset;
      rem_latency <= RemLatReset;
    end else if (cfg_we && paddr[1:0] == 2'b00) begin
      case (cfg_idx)
        RegMulLat: mul_latency <= pwdata[5:0];
        RegDivLat: div_latency <= pwdata[5:0];
        RegRemLat: rem_latency <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      RegMulLat: prdata = {26'd0, mul_latency};
      RegDivLat: prdata = {26'd0, div_latency};
      RegRemLat: prdata = {26'd0, rem_latency};
      default:   prdata = '0;
    endcase
  end

  // front: classification and latency bookkeeping
  assign in_ready = !qfull;
  assign take = in_valid && in_ready;

  rv64_front u_front (
    .clk, .rst, .take, .item(in_data),
    .mul_latency, .div_latency, .rem_latency, .work(fwork)
  );

  rv64_fifo u_fifo (
    .clk, .rst, .push(take), .push_data(fwork), .full(qfull),
    .pop(qpop), .empty(qempty), .pop_data(qwork)
  );

  // back starts only when the output holding register is free
  logic hold_valid;
  assign qpop = !qempty && !bbusy && !hold_valid && !bdone;

  rv64_back u_back (
    .clk, .rst, .start(qpop), .work(qwork),
    .busy(bbusy), .done(bdone), .res(bres)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (bdone) begin
      hold_valid <= 1'b1;
    end else if (out_ready) begin
      hold_valid <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (bdone) out_data <= bres;
  end
  assign out_valid = hold_valid;

  // a stalled result beat stays put until taken
  a_out_no_stall_loss: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat lost under stall");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    qfull |-> !take)
    else $error("queue overflow");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    qpop |-> !bbusy && !hold_valid)
    else $error("back started while busy");
  a_width: assert property (@(posedge clk) DATA_WIDTH == 64)
    else $error("only 64-bit data supported");
endmodule

### bench/rv64im_alu_with_latency_model_core_tb.sv
// testbench for the rv64im alu with modelled latency: directed table, random beats, scoreboard
module rv64im_alu_with_latency_model_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rv64_pkg::*;

  localparam logic [63:0] Msb = 64'h8000_0000_0000_0000;
  localparam logic [63:0] Ones = '1;
  localparam int NumRandom = 925;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  rv64im_alu_with_latency_model_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state: latency registers and history of the previous beat
  logic [5:0] lat_mul, lat_div, lat_rem;
  logic hist_mul, hist_div, hist_div_u;
  logic [63:0] last_a, last_b;

  out_item_t alu_expect_q[$];
  int errors;
  bit quiet_tail;      // no idling on either side near the end
  bit hold_sink;       // long receiver stall requested by the driver
  bit hold_done;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("FAIL rv64im_alu_with_latency_model_core");
    $finish;
  end

  function automatic logic [63:0] sx32(input logic [63:0] x);
    return {{32{x[31]}}, x[31:0]};
  endfunction

  // signed division with the risc-v rules for zero divisor and overflow
  function automatic logic [63:0] signed_divide(input logic [63:0] a, input logic [63:0] b,
                                                input bit want_rem);
    logic [63:0] ua, ub, q, r;
    if (b == 0) return want_rem ? a : Ones;
    if (a == Msb && b == Ones) return want_rem ? 64'd0 : a;
    ua = a[63] ? -a : a;
    ub = b[63] ? -b : b;
    q = ua / ub;
    r = ua % ub;
    if (want_rem) return a[63] ? -r : r;
    return (a[63] != b[63]) ? -q : q;
  endfunction

  // computes the result and modelled latency of one beat and advances history
  function automatic out_item_t alu_predict(input in_item_t it);
    out_item_t o;
    logic [63:0] a, b, res;
    logic [127:0] prod;
    logic [5:0] lat;
    bit is_mul, is_div, keep, same;
    int rem_kind;
    a = it.operand_a;
    b = it.operand_b;
    res = it.passthrough_value;
    lat = it.latency_in;
    is_mul = 0; is_div = 0; keep = 0; rem_kind = -1;
    same = (a == last_a) && (b == last_b);
    case (it.cmd)
      OP_NOP: ;
      OP_ADD: res = a + b;
      OP_MUL: begin res = a * b; is_mul = 1; end
      OP_SUB: res = a - b;
      OP_SLL: res = a << b[5:0];
      OP_MULH: begin
        prod = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
        res = prod[127:64]; is_mul = 1;
      end
      OP_MULHSU: begin
        prod = {{64{a[63]}}, a} * {64'd0, b};
        res = prod[127:64]; is_mul = 1;
      end
      OP_MULHU: begin
        prod = {64'd0, a} * {64'd0, b};
        res = prod[127:64]; is_mul = 1;
      end
      OP_SLT: res = ($signed(a) < $signed(b)) ? 64'd1 : 64'd0;
      OP_SLTU: res = (a < b) ? 64'd1 : 64'd0;
      OP_XOR: res = a ^ b;
      OP_DIV: begin res = signed_divide(a, b, 0); is_div = 1; hist_div_u = 0; end
      OP_DIVU: begin res = (b == 0) ? Ones : a / b; is_div = 1; hist_div_u = 1; end
      OP_SRL: res = a >> b[5:0];
      OP_SRA: res = $signed(a) >>> b[5:0];
      OP_OR: res = a | b;
      OP_REM: begin res = signed_divide(a, b, 1); rem_kind = 0; end
      OP_REMU: begin res = (b == 0) ? a : a % b; rem_kind = 1; end
      OP_AND: res = a & b;
      OP_ADDW: res = sx32(a + b);
      OP_SUBW: res = sx32(a - b);
      OP_SLLW: res = sx32(a << b[4:0]);
      OP_SRLW: res = sx32({32'd0, a[31:0]} >> b[4:0]);
      OP_SRAW: res = sx32($signed(sx32(a)) >>> b[4:0]);
      OP_MULW: res = sx32(a * b);
      OP_DIVW: begin
        res = sx32(signed_divide(sx32(a), sx32(b), 0)); is_div = 1; hist_div_u = 0;
      end
      OP_REMW: begin res = sx32(signed_divide(sx32(a), sx32(b), 1)); rem_kind = 0; end
      OP_REMUW: begin
        res = sx32((b[31:0] == 0) ? {32'd0, a[31:0]} : {32'd0, a[31:0] % b[31:0]});
        rem_kind = 1;
      end
      default: keep = 1;
    endcase
    if (is_mul) begin
      lat = hist_mul ? ((lat_mul == 0) ? 6'd0 : lat_mul - 6'd1) : lat_mul;
    end else if (is_div) begin
      lat = lat_div;
    end else if (rem_kind >= 0) begin
      lat = (hist_div && same && (hist_div_u == (rem_kind == 1))) ? 6'd0 : lat_rem;
    end
    if (!keep) begin
      hist_mul = is_mul;
      hist_div = is_div;
    end
    last_a = a;
    last_b = b;
    o.result = res;
    o.latency_out = lat;
    return o;
  endfunction

  // apb write: setup then access, register taken when pready is high
  task automatic reg_write(input logic [1:0] idx, input logic [5:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= {26'd0, val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(negedge clk);
    case (idx)
      RegMulLat: lat_mul = val;
      RegDivLat: lat_div = val;
      default: lat_rem = val;
    endcase
  endtask

  // wait for the queue to drain plus the slowest back end latency
  task automatic drain;
    in_valid <= 1'b0;
    while (alu_expect_q.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  // one input beat; the expectation is pushed at the accepting edge
  task automatic send_beat(input in_item_t it, input bit may_idle);
    if (may_idle && !quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    alu_expect_q.push_back(alu_predict(it));
    @(negedge clk);
  endtask

  function automatic logic [63:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return 64'd0;
      1: return Ones;
      2: return Msb;
      3: return {$urandom, $urandom} & 64'hff;
      4: return sx32({32'd0, $urandom});
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic in_item_t rand_beat();
    in_item_t it;
    it.cmd = 5'($urandom_range(0, 31));
    it.operand_a = rand_operand();
    it.operand_b = rand_operand();
    it.passthrough_value = {$urandom, $urandom};
    it.latency_in = 6'($urandom_range(0, 63));
    return it;
  endfunction

  // directed table; expected value typed in only where obvious, else predictor
  typedef struct {
    logic [4:0] cmd;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] pv;
    logic [5:0] lin;
    bit typed;
    logic [63:0] res;
    logic [5:0] lat;
  } dir_row_t;

  dir_row_t dir_rows[] = '{
    // nop right after reset returns passthrough and latency_in
    '{OP_NOP, 64'd0, 64'd0, Ones, 6'd63, 1'b1, Ones, 6'd63},
    '{OP_ADD, Ones, 64'd1, 64'd0, 6'd5, 1'b1, 64'd0, 6'd5},
    '{OP_SUB, 64'd0, 64'd1, 64'd0, 6'd0, 1'b1, Ones, 6'd0},
    '{OP_MUL, Ones, Ones, 64'd0, 6'd0, 1'b1, 64'd1, 6'd2},
    // back-to-back multiplies get the reduced modelled latency
    '{OP_MULH, Msb, Msb, 64'd0, 6'd0, 1'b0, 64'd0, 6'd0},
    '{OP_MULHSU, Ones, Ones, 64'd0, 6'd0, 1'b0, 64'd0, 6'd0},
    '{OP_MULHU, Ones, Ones, 64'd0, 6'd0, 1'b1, 64'hffff_ffff_ffff_fffe, 6'd1},
    '{OP_MULW, 64'h7fff_ffff, 64'd2, 64'd0, 6'd9, 1'b0, 64'd0, 6'd0},
    // zero divisor then fused remainder with same operands
    '{OP_DIV, 64'd7, 64'd0, 64'd0, 6'd0, 1'b1, Ones, 6'd40},
    '{OP_REM, 64'd7, 64'd0, 64'd0, 6'd0, 1'b1, 64'd7, 6'd0},
    // signed overflow
    '{OP_DIV, Msb, Ones, 64'd0, 6'd0, 1'b1, Msb, 6'd40},
    '{OP_REM, Msb, Ones, 64'd0, 6'd0, 1'b1, 64'd0, 6'd0},
    // signedness mismatch: not fused
    '{OP_DIVU, 64'd100, 64'd7, 64'd0, 6'd0, 1'b0, 64'd0, 6'd0},
    '{OP_REM, 64'd100, 64'd7, 64'd0, 6'd0, 1'b0, 64'd0, 6'd0},
    '{OP_REMU, Ones, 64'd0, 64'd0, 6'd0, 1'b1, Ones, 6'd40},
    '{OP_DIVW, 64'h8000_0000, 64'hffff_ffff, 64'd0, 6'd0, 1'b0, 64'd0, 6'd0},
    '{OP_REMW, 64'h8000_0000, 64'hffff_ffff, 64'd0, 6'd0, 1'b0, 64'd0, 6'd0},
    '{OP_REMUW, 64'h1_8000_0000, 64'h1_0000_0000, 64'd0, 6'd0, 1'b0, 64'd0, 6'd0},
    // unknown code keeps the flags; rem after it stays fused
    '{OP_DIVU, 64'd9, 64'd4, 64'd0, 6'd0, 1'b0, 64'd0, 6'd0},
    '{5'd31, 64'd9, 64'd4, 64'h1234, 6'd17, 1'b1, 64'h1234, 6'd17},
    '{OP_REMU, 64'd9, 64'd4, 64'd0, 6'd0, 1'b1, 64'd1, 6'd0},
    '{OP_SRLW, Ones, 64'd63, 64'd0, 6'd0, 1'b0, 64'd0, 6'd0},
    '{OP_SRAW, 64'h8000_0000, 64'd31, 64'd0, 6'd0, 1'b1, Ones, 6'd0},
    '{OP_SLT, Msb, 64'd0, 64'd0, 6'd3, 1'b1, 64'd1, 6'd3},
    '{OP_SRA, Msb, 64'd63, 64'd0, 6'd0, 1'b1, Ones, 6'd0}
  };

  // result side: random stall bursts, plus the long stall when asked
  initial begin
    int stall;
    out_ready = 1'b0;
    hold_done = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_sink && !hold_done) begin
        out_ready <= 1'b0;
        repeat (200) @(negedge clk);
        hold_done = 1;
      end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        stall = $urandom_range(1, 5);
        repeat (stall) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // scoreboard: compare each accepted result beat against the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (alu_expect_q.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, out_data);
        errors++;
      end else begin
        want = alu_expect_q.pop_front();
        if (out_data.result !== want.result) begin
          $display("%0t: result expected %h actual %h", $time, want.result,
                   out_data.result);
          errors++;
        end
        if (out_data.latency_out !== want.latency_out) begin
          $display("%0t: latency expected %0d actual %0d", $time, want.latency_out,
                   out_data.latency_out);
          errors++;
        end
      end
    end
  end

  initial begin
    in_item_t it;
    out_item_t typed_want;
    errors = 0;
    quiet_tail = 0;
    hold_sink = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    lat_mul = MulLatReset; lat_div = DivLatReset; lat_rem = RemLatReset;
    hist_mul = 0; hist_div = 0; hist_div_u = 0; last_a = '0; last_b = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part at reset latencies
    foreach (dir_rows[i]) begin
      it.cmd = dir_rows[i].cmd;
      it.operand_a = dir_rows[i].a;
      it.operand_b = dir_rows[i].b;
      it.passthrough_value = dir_rows[i].pv;
      it.latency_in = dir_rows[i].lin;
      send_beat(it, 1);
      if (dir_rows[i].typed) begin
        typed_want = alu_expect_q[$];
        if (typed_want.result !== dir_rows[i].res ||
            typed_want.latency_out !== dir_rows[i].lat) begin
          $display("%0t: table row %0d expected %h/%0d predictor %h/%0d", $time, i,
                   dir_rows[i].res, dir_rows[i].lat, typed_want.result,
                   typed_want.latency_out);
          errors++;
        end
      end
    end
    // sender pause until every result is back
    drain();

    // random part in phases; latency settings cover both extremes
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin reg_write(RegMulLat, 6'd0); reg_write(RegDivLat, 6'd0);
                 reg_write(RegRemLat, 6'd0); end
        1: begin reg_write(RegMulLat, 6'd63); reg_write(RegDivLat, 6'd63);
                 reg_write(RegRemLat, 6'd63); end
        2: begin reg_write(RegMulLat, 6'd1); reg_write(RegDivLat, 6'd17);
                 reg_write(RegRemLat, 6'd33); end
        default: begin reg_write(RegMulLat, 6'($urandom_range(1, 63)));
                 reg_write(RegDivLat, 6'($urandom_range(0, 63)));
                 reg_write(RegRemLat, 6'($urandom_range(0, 63))); end
      endcase
      if (ph == 2) hold_sink = 1;  // long receiver stall while beats keep coming
      if (ph == 4) quiet_tail = 1;
      for (int n = 0; n < NumRandom / 5; n++) begin
        it = rand_beat();
        // most beats form div/rem or mul pairs so the fused paths are hit
        if ($urandom_range(0, 2) == 0) begin
          it.cmd = $urandom_range(0, 1) ? OP_DIV : ($urandom_range(0, 1) ? OP_DIVU : OP_DIVW);
          send_beat(it, 1);
          n++;
          if ($urandom_range(0, 3) == 0) begin it.operand_b = rand_operand(); end
          case ($urandom_range(0, 3))
            0: it.cmd = OP_REM;
            1: it.cmd = OP_REMU;
            2: it.cmd = OP_REMW;
            default: it.cmd = OP_REMUW;
          endcase
        end else if ($urandom_range(0, 3) == 0) begin
          it.cmd = OP_MUL;
          send_beat(it, 1);
          n++;
          it = rand_beat();
          case ($urandom_range(0, 3))
            0: it.cmd = OP_MUL;
            1: it.cmd = OP_MULH;
            2: it.cmd = OP_MULHSU;
            default: it.cmd = OP_MULHU;
          endcase
        end
        send_beat(it, 1);
      end
      drain();
    end

    if (errors == 0 && alu_expect_q.size() == 0) begin
      $display("PASS rv64im_alu_with_latency_model_core");
    end else begin
      if (alu_expect_q.size() != 0)
        $display("%0t: %0d expected results never arrived", $time, alu_expect_q.size());
      $display("FAIL rv64im_alu_with_latency_model_core");
    end
    $finish;
  end

endmodule
